@@ rtl/core/pcc_pkg.sv @@
`default_nettype none

package pcc_pkg;

    localparam int ITERATIONS_DEF = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Width of the binary angle register and headroom bits above the Q16.16 guard range.
    localparam int Z_W      = 34;
    localparam int HEADROOM = 2;
    // Width of x or y once the guard bits are dropped.
    localparam int XR_W     = 32 + HEADROOM;

    // 1/K of the CORDIC gain in Q0.32.
    localparam logic [31:0] INV_GAIN     = 32'h9B74_EDA8;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

    // Degrees to binary angle: round(deg * 8192 / 45) through a reciprocal multiply.
    localparam int          DEG_SHIFT       = 46;
    localparam int          DEG_SCALE_SHIFT = 13;
    localparam int          DEG_Q_LSB       = DEG_SHIFT - DEG_SCALE_SHIFT;
    localparam logic [63:0] DEG_DIVISOR     = 64'd45;
    localparam logic [40:0] DEG_RECIP       =
        41'(((64'd1 << DEG_SHIFT) / DEG_DIVISOR) + 64'd1);
    // Rounding offset of 22 units scaled by the reciprocal, with the 2^13 factor taken out.
    localparam logic [63:0] DEG_BIAS        = (64'd22 * 64'(DEG_RECIP)) >> DEG_SCALE_SHIFT;

    // Binary angle to degrees: (s * 45 + 4096) >> 13.
    localparam logic [37:0] ANGLE_GAIN  = 38'd45;
    localparam logic [37:0] ANGLE_ROUND = 38'd4096;
    localparam int          ANGLE_SHIFT = 13;
    // 180 degrees in Q16.16.
    localparam logic signed [31:0] ANGLE_LIMIT = 32'sd11796480;

    typedef enum logic {
        OP_POLAR_TO_RECT = 1'b0,
        OP_RECT_TO_POLAR = 1'b1
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
        logic zero;
    } t_ctl;

    function automatic logic [31:0] atan_entry(input int idx);
        logic [31:0] a;
        case (idx)
            0:       a = 32'h2000_0000;
            1:       a = 32'h12E4_051E;
            2:       a = 32'h09FB_385B;
            3:       a = 32'h0511_11D4;
            4:       a = 32'h028B_0D43;
            5:       a = 32'h0145_D7E1;
            6:       a = 32'h00A2_F61E;
            7:       a = 32'h0051_7C55;
            8:       a = 32'h0028_BE53;
            9:       a = 32'h0014_5F2F;
            10:      a = 32'h000A_2F98;
            11:      a = 32'h0005_17CC;
            12:      a = 32'h0002_8BE6;
            13:      a = 32'h0001_45F3;
            14:      a = 32'h0000_A2FA;
            15:      a = 32'h0000_517D;
            16:      a = 32'h0000_28BE;
            17:      a = 32'h0000_145F;
            18:      a = 32'h0000_0A30;
            19:      a = 32'h0000_0518;
            20:      a = 32'h0000_028C;
            21:      a = 32'h0000_0146;
            22:      a = 32'h0000_00A3;
            23:      a = 32'h0000_0051;
            24:      a = 32'h0000_0029;
            25:      a = 32'h0000_0014;
            26:      a = 32'h0000_000A;
            27:      a = 32'h0000_0005;
            28:      a = 32'h0000_0003;
            29:      a = 32'h0000_0001;
            default: a = 32'h0000_0000;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/polar_rect_converter_core.sv @@
// Structure: three preparation stages, one stage per CORDIC iteration and two output stages
// lie between the accepting edge and the result strobe.
// Throughput: one item per cycle while busy is low; the receiver cannot stall, so nothing ever holds the pipe.
// Reset (synchronous, active low) clears the valid bit of every stage; busy is high while
// reset is applied and until the first clock edge after reset is released, and low from then on.
`default_nettype none

module polar_rect_converter_core #(
    parameter int ITERATIONS = pcc_pkg::ITERATIONS_DEF,
    parameter int DATA_WIDTH = pcc_pkg::DATA_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_operation,
    input  logic signed [31:0] i_first_operand,
    input  logic signed [25:0] i_second_operand,
    output logic               o_valid,
    output logic signed [31:0] o_first_result,
    output logic signed [31:0] o_second_result
);
    import pcc_pkg::*;

    localparam int GUARD   = (DATA_WIDTH - 16) / 2;
    localparam int W       = 32 + GUARD + HEADROOM;
    localparam int LATENCY = ITERATIONS + 5;

    logic r_busy;
    logic accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy   = r_busy;
    assign accept = start && !busy;

    t_ctl                  ctl_pipe [ITERATIONS+1];
    logic signed [W-1:0]   x_pipe   [ITERATIONS+1];
    logic signed [W-1:0]   y_pipe   [ITERATIONS+1];
    logic signed [Z_W-1:0] z_pipe   [ITERATIONS+1];

    pcc_prep #(
        .GUARD (GUARD),
        .W     (W)
    ) u_prep (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (accept),
        .i_operation      (i_operation),
        .i_first_operand  (i_first_operand),
        .i_second_operand (i_second_operand),
        .o_ctl            (ctl_pipe[0]),
        .o_x              (x_pipe[0]),
        .o_y              (y_pipe[0]),
        .o_z              (z_pipe[0])
    );

    for (genvar g = 0; g < ITERATIONS; g++) begin : g_iter
        pcc_cordic_stage #(
            .IDX (g),
            .W   (W)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl_pipe[g]),
            .i_x     (x_pipe[g]),
            .i_y     (y_pipe[g]),
            .i_z     (z_pipe[g]),
            .o_ctl   (ctl_pipe[g+1]),
            .o_x     (x_pipe[g+1]),
            .o_y     (y_pipe[g+1]),
            .o_z     (z_pipe[g+1])
        );
    end

    pcc_post #(
        .GUARD (GUARD),
        .W     (W)
    ) u_post (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl_pipe[ITERATIONS]),
        .i_x             (x_pipe[ITERATIONS]),
        .i_y             (y_pipe[ITERATIONS]),
        .i_z             (z_pipe[ITERATIONS]),
        .o_valid         (o_valid),
        .o_first_result  (o_first_result),
        .o_second_result (o_second_result)
    );

    // Every result strobe belongs to an item that was accepted into the pipeline.
    a_strobe_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, LATENCY))
        else $error("result strobe without a matching accepted item");

    a_zero_vector : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(accept && i_operation && (i_first_operand == '0)
                          && (i_second_operand == '0), LATENCY))
        |-> ((o_first_result == '0) && (o_second_result == '0)))
        else $error("zero vector did not give zero magnitude and angle");

    a_angle_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_operation, LATENCY))
        |-> ((o_second_result >= -ANGLE_LIMIT) && (o_second_result <= ANGLE_LIMIT)))
        else $error("angle result outside -180..180 degrees");

endmodule

`default_nettype wire

@@ rtl/core/pcc_prep.sv @@
`default_nettype none

module pcc_prep #(
    parameter int GUARD = 8,
    parameter int W     = 42
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         i_operation,
    input  logic signed [31:0]           i_first_operand,
    input  logic signed [25:0]           i_second_operand,
    output pcc_pkg::t_ctl                o_ctl,
    output logic signed [W-1:0]          o_x,
    output logic signed [W-1:0]          o_y,
    output logic signed [pcc_pkg::Z_W-1:0] o_z
);
    import pcc_pkg::*;

    localparam int          SH      = 32 - GUARD;
    localparam int          RW      = 32 + GUARD;
    localparam logic [63:0] PX_HALF = 64'd1 << (SH - 1);
    localparam logic [57:0] QY_HALF = 58'd1 << (SH - 1);
    localparam logic [19:0] M_HI    = DEG_RECIP[40:21];
    localparam logic [20:0] M_LO    = DEG_RECIP[20:0];
    localparam logic signed [Z_W-1:0] Z_QUARTER = Z_W'(QUARTER_TURN);
    localparam logic signed [Z_W-1:0] Z_HALF    = Z_W'(HALF_TURN);

    // Stage 1: operand magnitudes times 1/K and times the degree reciprocal.
    logic        p_neg;
    logic        q_neg;
    logic [31:0] p_mag;
    logic [25:0] q_mag;
    t_ctl        n1_ctl;

    t_ctl        r1_ctl;
    logic        r1_pneg;
    logic        r1_qneg;
    logic [63:0] r1_px;
    logic [57:0] r1_qy;
    logic [45:0] r1_dh;
    logic [46:0] r1_dl;

    assign p_neg = i_first_operand[31];
    assign q_neg = i_second_operand[25];
    assign p_mag = p_neg ? 32'(-i_first_operand) : 32'(i_first_operand);
    assign q_mag = q_neg ? 26'(-i_second_operand) : 26'(i_second_operand);

    always_comb begin
        n1_ctl.valid = i_valid;
        n1_ctl.op    = t_op'(i_operation);
        n1_ctl.zero  = (i_first_operand == '0) && (i_second_operand == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
        end else begin
            r1_ctl <= n1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_pneg <= p_neg;
        r1_qneg <= q_neg;
        r1_px   <= 64'(p_mag) * 64'(INV_GAIN);
        r1_qy   <= 58'(q_mag) * 58'(INV_GAIN);
        r1_dh   <= 46'(q_mag) * 46'(M_HI);
        r1_dl   <= 47'(q_mag) * 47'(M_LO);
    end

    // Stage 2: round the prescaled magnitudes, finish the degree conversion.
    logic [RW-1:0] n2_rx;
    logic [RW-1:0] n2_ry;
    logic [66:0]   deg_sum;
    logic [31:0]   deg_q;
    logic [31:0]   n2_bam;

    t_ctl          r2_ctl;
    logic          r2_pneg;
    logic          r2_qneg;
    logic [RW-1:0] r2_rx;
    logic [RW-1:0] r2_ry;
    logic [31:0]   r2_bam;

    assign n2_rx   = RW'((r1_px + PX_HALF) >> SH);
    assign n2_ry   = RW'((r1_qy + QY_HALF) >> SH);
    assign deg_sum = {r1_dh, 21'd0} + 67'(r1_dl) + 67'(DEG_BIAS);
    assign deg_q   = deg_sum[DEG_Q_LSB +: 32];
    // The sign is applied after rounding the magnitude, and the turn wraps modulo 2^32.
    assign n2_bam  = r1_qneg ? 32'(-deg_q) : deg_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else begin
            r2_ctl <= r1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_pneg <= r1_pneg;
        r2_qneg <= r1_qneg;
        r2_rx   <= n2_rx;
        r2_ry   <= n2_ry;
        r2_bam  <= n2_bam;
    end

    // Stage 3: bring the vector into the right half plane.
    logic signed [31:0]    bam_s;
    logic signed [Z_W-1:0] zs;
    logic signed [W-1:0]   rx_ext;
    logic signed [W-1:0]   ry_ext;
    logic                  flip_hi;
    logic                  flip_lo;
    logic                  x_flip;
    logic signed [W-1:0]   n3_x;
    logic signed [W-1:0]   n3_y;
    logic signed [Z_W-1:0] n3_z;

    t_ctl                  r3_ctl;
    logic signed [W-1:0]   r3_x;
    logic signed [W-1:0]   r3_y;
    logic signed [Z_W-1:0] r3_z;

    assign bam_s  = r2_bam;
    assign zs     = Z_W'(bam_s);
    assign rx_ext = W'(r2_rx);
    assign ry_ext = W'(r2_ry);

    always_comb begin
        flip_hi = zs > Z_QUARTER;
        flip_lo = zs < -Z_QUARTER;
        x_flip  = 1'b0;
        n3_x    = rx_ext;
        n3_y    = '0;
        n3_z    = zs;
        if (r2_ctl.op == OP_POLAR_TO_RECT) begin
            if (flip_hi) begin
                n3_z = zs - Z_HALF;
            end else if (flip_lo) begin
                n3_z = zs + Z_HALF;
            end
            n3_x = (r2_pneg ^ (flip_hi | flip_lo)) ? -rx_ext : rx_ext;
        end else begin
            // A negative x that rounded to zero is not mirrored.
            x_flip = r2_pneg && (r2_rx != '0);
            n3_x   = rx_ext;
            n3_y   = (r2_qneg ^ x_flip) ? -ry_ext : ry_ext;
            n3_z   = x_flip ? Z_HALF : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl <= '0;
        end else begin
            r3_ctl <= r2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_x <= n3_x;
        r3_y <= n3_y;
        r3_z <= n3_z;
    end

    assign o_ctl = r3_ctl;
    assign o_x   = r3_x;
    assign o_y   = r3_y;
    assign o_z   = r3_z;

endmodule

`default_nettype wire

@@ rtl/core/pcc_cordic_stage.sv @@
`default_nettype none

module pcc_cordic_stage #(
    parameter int IDX = 0,
    parameter int W   = 42
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pcc_pkg::t_ctl                  i_ctl,
    input  logic signed [W-1:0]            i_x,
    input  logic signed [W-1:0]            i_y,
    input  logic signed [pcc_pkg::Z_W-1:0] i_z,
    output pcc_pkg::t_ctl                  o_ctl,
    output logic signed [W-1:0]            o_x,
    output logic signed [W-1:0]            o_y,
    output logic signed [pcc_pkg::Z_W-1:0] o_z
);
    import pcc_pkg::*;

    localparam logic signed [Z_W-1:0] ANGLE_STEP = Z_W'(atan_entry(IDX));

    logic                  cw;
    logic signed [W-1:0]   dx;
    logic signed [W-1:0]   dy;
    logic signed [W-1:0]   n_x;
    logic signed [W-1:0]   n_y;
    logic signed [Z_W-1:0] n_z;

    t_ctl                  r_ctl;
    logic signed [W-1:0]   r_x;
    logic signed [W-1:0]   r_y;
    logic signed [Z_W-1:0] r_z;

    // Rotation drives z to zero; vectoring drives y to zero.
    assign cw = (i_ctl.op == OP_RECT_TO_POLAR) ? i_y[W-1] : !i_z[Z_W-1];
    assign dx = i_y >>> IDX;
    assign dy = i_x >>> IDX;

    always_comb begin
        if (cw) begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - ANGLE_STEP;
        end else begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + ANGLE_STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

`default_nettype wire

@@ rtl/core/pcc_post.sv @@
`default_nettype none

module pcc_post #(
    parameter int GUARD = 8,
    parameter int W     = 42
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pcc_pkg::t_ctl                  i_ctl,
    input  logic signed [W-1:0]            i_x,
    input  logic signed [W-1:0]            i_y,
    input  logic signed [pcc_pkg::Z_W-1:0] i_z,
    output logic                           o_valid,
    output logic signed [31:0]             o_first_result,
    output logic signed [31:0]             o_second_result
);
    import pcc_pkg::*;

    localparam logic signed [W-1:0]    ROUND_HALF = W'((64'd1 << GUARD) >> 1);
    localparam logic signed [XR_W-1:0] SAT_MAX    = XR_W'(32'sh7FFF_FFFF);
    localparam logic signed [XR_W-1:0] SAT_MIN    = XR_W'(32'sh8000_0000);

    function automatic logic [31:0] sat32(input logic signed [XR_W-1:0] v);
        logic [31:0] s;
        if (v > SAT_MAX) begin
            s = 32'h7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            s = 32'h8000_0000;
        end else begin
            s = 32'(v);
        end
        return s;
    endfunction

    // Stage A: drop the guard bits, scale the binary angle to degrees.
    logic signed [W-1:0]    x_sum;
    logic signed [W-1:0]    y_sum;
    logic signed [31:0]     s_bam;
    logic [31:0]            s_mag;
    logic [37:0]            n_a_mag;

    t_ctl                   r_a_ctl;
    logic signed [XR_W-1:0] r_a_xr;
    logic signed [XR_W-1:0] r_a_yr;
    logic                   r_a_sneg;
    logic [37:0]            r_a_mag;

    assign x_sum   = i_x + ROUND_HALF;
    assign y_sum   = i_y + ROUND_HALF;
    assign s_bam   = i_z[31:0];
    assign s_mag   = s_bam[31] ? 32'(-s_bam) : 32'(s_bam);
    assign n_a_mag = 38'(s_mag) * ANGLE_GAIN + ANGLE_ROUND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
        end else begin
            r_a_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_xr   <= XR_W'(x_sum >>> GUARD);
        r_a_yr   <= XR_W'(y_sum >>> GUARD);
        r_a_sneg <= s_bam[31];
        r_a_mag  <= n_a_mag;
    end

    // Stage B: saturate and select the result item.
    logic [31:0] angle_q;
    logic [31:0] angle;
    logic [31:0] n_first;
    logic [31:0] n_second;

    logic        r_valid;
    logic [31:0] r_first;
    logic [31:0] r_second;

    assign angle_q = 32'(r_a_mag >> ANGLE_SHIFT);
    assign angle   = r_a_sneg ? 32'(-angle_q) : angle_q;

    always_comb begin
        n_first  = sat32(r_a_xr);
        n_second = sat32(r_a_yr);
        if (r_a_ctl.op == OP_RECT_TO_POLAR) begin
            n_second = angle;
            // The zero vector has no direction; both results read zero.
            if (r_a_ctl.zero) begin
                n_first  = '0;
                n_second = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_a_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first  <= n_first;
        r_second <= n_second;
    end

    assign o_valid         = r_valid;
    assign o_first_result  = r_first;
    assign o_second_result = r_second;

endmodule

`default_nettype wire
